// ===== design/spq_pkg.sv =====
// Shared types and codes for the sorted-insert priority queue.
// No dependencies; used by spq_cell and sorted_insert_priority_queue.
`default_nettype none

package spq_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned KEY_W     = 8;
    localparam int unsigned TAG_W     = 16;
    localparam int unsigned PAY_W     = 8;
    localparam int unsigned CNT_OUT_W = 5;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_EMPTY     = 2'd3
    } spq_status_t;

    // One stored entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] pay;
    } spq_entry_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             rem;
        spq_entry_t       item;
    } spq_op_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// One cell of the sorted row: holds a single entry and hands it to a neighbor.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::spq_op_t   op,
    input  wire logic               occ,        // this cell holds an entry
    input  wire logic               prev_ge,    // cell above keeps its entry
    input  wire spq_pkg::spq_entry_t prev_entry,
    input  wire spq_pkg::spq_entry_t next_entry,
    output logic                    ge,
    output spq_pkg::spq_entry_t     entry,
    output spq_pkg::spq_entry_t     entry_next
);
    import spq_pkg::*;

    spq_entry_t entry_reg;

    // Keep own entry when it ranks at or above the new key
    assign ge    = occ && (entry_reg.key >= op.item.key);
    assign entry = entry_reg;

    // Select: keep, take new item, shift down from above, or shift up from below
    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins && !ge)
        begin
            entry_next = prev_ge ? op.item : prev_entry;
        end
        else if (op.rem)
        begin
            entry_next = next_entry;
        end
    end

    // Data register, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== design/sorted_insert_priority_queue.sv =====
// Top level of the sorted-insert priority queue: a row of spq_cell instances,
// occupancy count and registered result stage. Depends on spq_pkg, spq_cell.
//
// Usage:
//   Input channel s_axis: tuser[0] selects the action (0 insert, 1 remove the
//   head); tdata carries priority, tag and payload of an insert. Output
//   channel m_axis: one result transaction per input transaction; tuser is
//   the status, tdata the removed entry, count and head/tail tags.
//   Entries are kept sorted by descending priority in a row of DEPTH cells;
//   every cell compares the new key against its own and shifts in the same
//   cycle, so an insert or remove completes in a single register update.
//   The result is registered and presented in the cycle after the input
//   transaction. One transaction per cycle while the receiver takes results;
//   s_axis_tready is high whenever the result register is empty or being
//   taken in the same cycle. When the receiver stalls, the result is held
//   and the input side stalls with it once the result register is occupied.
//   Reset clears the entry count (queue empty) and the result valid flag;
//   no clearing pass is needed, the queue is usable right after reset.
`default_nettype none

module sorted_insert_priority_queue #(
    parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // priority_req[7:0], tag[23:8], payload[31:24]
    input  wire logic [0:0]  s_axis_tuser,   // action[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // out_tag[15:0], out_priority[23:16],
                                             // out_payload[31:24], entry_count[36:32],
                                             // head_tag[52:37], tail_tag[68:53], zero fill
    output logic [1:0]       m_axis_tuser    // status[1:0]
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic             out_valid_reg;
    logic [71:0]      out_data_reg, out_data_next;
    spq_status_t      status_reg, status_next;

    logic             accept, action, full, empty;
    spq_op_t          op;
    spq_entry_t       cur   [DEPTH];
    spq_entry_t       nxt   [DEPTH];
    spq_entry_t       below [DEPTH];
    spq_entry_t       above [DEPTH];
    logic [DEPTH-1:0] ge, occ;
    logic [DEPTH:0]   ge_in;
    logic [DEPTH:0]   nocc;
    logic [TAG_W-1:0] tail_tag, head_tag;
    spq_entry_t       removed;
    logic [CNT_OUT_W-1:0] count_out;

    // Handshake
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = s_axis_tuser[0];
    assign full          = (count_reg == CW'(DEPTH));
    assign empty         = (count_reg == '0);

    // Broadcast operation
    assign op.ins       = accept && !action && !full;
    assign op.rem       = accept && action && !empty;
    assign op.item.key  = s_axis_tdata[7:0];
    assign op.item.tag  = s_axis_tdata[23:8];
    assign op.item.pay  = s_axis_tdata[31:24];

    // Next count
    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Occupancy and neighbor wiring
    assign ge_in[0] = 1'b1;
    assign nocc[DEPTH] = 1'b0;
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_row
        assign occ[i]     = (count_reg > CW'(i));
        assign nocc[i]    = (count_next > CW'(i));
        assign ge_in[i+1] = ge[i];
        assign above[i]   = (i == 0) ? op.item : cur[(i == 0) ? 0 : i-1];
        assign below[i]   = (i == DEPTH-1) ? '0 : cur[(i == DEPTH-1) ? i : i+1];

        spq_cell u_cell (
            .clk        (clk),
            .op         (op),
            .occ        (occ[i]),
            .prev_ge    (ge_in[i]),
            .prev_entry (above[i]),
            .next_entry (below[i]),
            .ge         (ge[i]),
            .entry      (cur[i]),
            .entry_next (nxt[i])
        );
    end

    // Head and tail tags after this step
    always_comb
    begin
        tail_tag = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (nocc[i] && !nocc[i+1])
            begin
                tail_tag = tail_tag | nxt[i].tag;
            end
        end
        head_tag = nocc[0] ? nxt[0].tag : '0;
    end

    // Result fields
    assign removed   = op.rem ? cur[0] : '0;
    assign count_out = CNT_OUT_W'(count_next);

    always_comb
    begin
        if (!action)
        begin
            status_next = full ? ST_FULL : ST_INSERTED;
        end
        else
        begin
            status_next = empty ? ST_EMPTY : ST_REMOVED;
        end
        out_data_next = {3'b000, tail_tag, head_tag, count_out,
                         removed.pay, removed.key, removed.tag};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            status_reg   <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = status_reg;

    // Count never runs past the number of cells
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // A remove on a non-empty queue drops the count by one
    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action && !empty) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("remove did not decrement count");

    // An insert on a full queue leaves it full and reports rejection
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !action && full) |=> (full && m_axis_tuser == ST_FULL))
        else $error("insert on full queue changed state");

    // Reported count matches the internal count right after a transaction
    a_count_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (m_axis_tdata[36:32] == CNT_OUT_W'(count_reg)))
        else $error("reported count differs from held count");

endmodule

`default_nettype wire
